>>> rtl/bcr_pkg.sv
// Shared types, constants and weight arithmetic of the bicubic resampler.
`default_nettype none

package bcr_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int MAX_SIZE_DEF = 128;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_REQ  = 1'b1;

   typedef enum logic [1:0] {
      CSR_SRC_HEIGHT      = 2'd0,
      CSR_SRC_WIDTH       = 2'd1,
      CSR_VERTICAL_STEP   = 2'd2,
      CSR_HORIZONTAL_STEP = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [7:0]  src_height;
      logic [7:0]  src_width;
      logic [23:0] vertical_step;
      logic [23:0] horizontal_step;
   } cfg_type;

   typedef struct packed {
      logic              func;
      logic [1:0]        plane;
      logic [6:0]        row;
      logic [6:0]        col;
      logic [15:0]       sample;
      logic [16:0]       i0x;
      logic [16:0]       i0y;
      logic [3:0][17:0]  wx;
      logic [3:0][17:0]  wy;
   } item_type;

   // outer tap weight: -0.75(f^3 - 2f^2 + f), Q2.14 rounded half up
   function automatic logic [17:0] wt_outer(input logic [43:0] f3, input logic [28:0] f2,
                                            input logic [14:0] f1);
      logic signed [47:0] a3;
      logic signed [47:0] a2;
      logic signed [47:0] a1;
      logic signed [47:0] e;
      logic signed [47:0] n;
      logic signed [47:0] r;
      a3 = 48'(f3);
      a2 = 48'(f2);
      a1 = 48'(f1);
      e = a3 - (a2 <<< 15) + (a1 <<< 28);
      n = -(e + (e <<< 1));
      r = (n + 48'sd536870912) >>> 30;
      return r[17:0];
   endfunction

   // inner tap weight: (5f^3 - 9f^2 + 4)/4, Q2.14 rounded half up
   function automatic logic [17:0] wt_inner(input logic [43:0] f3, input logic [28:0] f2);
      logic signed [47:0] a3;
      logic signed [47:0] a2;
      logic signed [47:0] n;
      logic signed [47:0] r;
      a3 = 48'(f3);
      a2 = 48'(f2);
      n = a3 + (a3 <<< 2) - (a2 <<< 14) - (a2 <<< 17) + (48'sd1 <<< 44);
      r = (n + 48'sd536870912) >>> 30;
      return r[17:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/bcr_if.sv
// Request and response channel interfaces of the bicubic resampler.
`default_nettype none

interface bcr_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [1:0]  plane;
   logic [6:0]  row;
   logic [6:0]  col;
   logic signed [15:0] sample;
   modport source (output valid, func, plane, row, col, sample, input ready);
   modport sink (input valid, func, plane, row, col, sample, output ready);
endinterface

interface bcr_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] value;
   logic        clipped;
   modport source (output valid, value, clipped, input ready);
   modport sink (input valid, value, clipped, output ready);
endinterface

`default_nettype wire

>>> rtl/bcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bcr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/bcr_queue.sv
// Two-entry queue between the front and back parts of the resampler.
`default_nettype none

module bcr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bcr_pkg::item_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output bcr_pkg::item_type      head,
   output logic                   empty
);

   bcr_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/bcr_front.sv
// Front part: accept words, work out base taps and cubic weights, queue them.
`default_nettype none

module bcr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bcr_pkg::cfg_type  cfg,
   bcr_req_if.sink                req,
   output logic                   push,
   output bcr_pkg::item_type      push_data,
   input  wire logic              full
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_SQ   = 4'b0010,
      F_CUBE = 4'b0100,
      F_PUSH = 4'b1000
   } fstate_type;

   fstate_type state_ff, state_in;

   logic        func_ff, func_in;
   logic [1:0]  plane_ff, plane_in;
   logic [6:0]  row_ff, row_in;
   logic [6:0]  col_ff, col_in;
   logic [15:0] sample_ff, sample_in;
   logic signed [32:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [16:0] i0x_ff, i0x_in, i0y_ff, i0y_in;
   logic [14:0] tx_ff, tx_in, ux_ff, ux_in, ty_ff, ty_in, uy_ff, uy_in;
   logic [28:0] t2x_ff, t2x_in, u2x_ff, u2x_in, t2y_ff, t2y_in, u2y_ff, u2y_in;
   logic [43:0] t3x_ff, t3x_in, u3x_ff, u3x_in, t3y_ff, t3y_in, u3y_ff, u3y_in;
   logic [31:0] prodx, prody;
   logic [17:0] w0x, w1x, w3x, w0y, w1y, w3y;

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      plane_in  = plane_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      sample_in = sample_ff;
      posx_in   = posx_ff;
      posy_in   = posy_ff;
      i0x_in    = i0x_ff;
      i0y_in    = i0y_ff;
      tx_in     = tx_ff;
      ux_in     = ux_ff;
      ty_in     = ty_ff;
      uy_in     = uy_ff;
      t2x_in    = t2x_ff;
      u2x_in    = u2x_ff;
      t2y_in    = t2y_ff;
      u2y_in    = u2y_ff;
      t3x_in    = t3x_ff;
      u3x_in    = u3x_ff;
      t3y_in    = t3y_ff;
      u3y_in    = u3y_ff;
      req.ready = 1'b0;
      push      = 1'b0;
      prodx     = 32'({req.col, 1'b1}) * 32'(cfg.horizontal_step);
      prody     = 32'({req.row, 1'b1}) * 32'(cfg.vertical_step);
      unique case (state_ff)
         F_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               func_in   = req.func;
               plane_in  = req.plane;
               row_in    = req.row;
               col_in    = req.col;
               sample_in = req.sample;
               posx_in   = $signed({1'b0, prodx}) - 33'sd65536;
               posy_in   = $signed({1'b0, prody}) - 33'sd65536;
               state_in  = F_SQ;
            end
         end
         F_SQ: begin
            i0x_in   = {posx_ff[32], posx_ff[32:17]};
            i0y_in   = {posy_ff[32], posy_ff[32:17]};
            tx_in    = {1'b0, posx_ff[16:3]};
            ty_in    = {1'b0, posy_ff[16:3]};
            ux_in    = 15'd16384 - {1'b0, posx_ff[16:3]};
            uy_in    = 15'd16384 - {1'b0, posy_ff[16:3]};
            t2x_in   = 29'(posx_ff[16:3] * posx_ff[16:3]);
            t2y_in   = 29'(posy_ff[16:3] * posy_ff[16:3]);
            u2x_in   = 29'(ux_in * ux_in);
            u2y_in   = 29'(uy_in * uy_in);
            state_in = F_CUBE;
         end
         F_CUBE: begin
            t3x_in   = 44'(t2x_ff * tx_ff);
            u3x_in   = 44'(u2x_ff * ux_ff);
            t3y_in   = 44'(t2y_ff * ty_ff);
            u3y_in   = 44'(u2y_ff * uy_ff);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      w0x = bcr_pkg::wt_outer(t3x_ff, t2x_ff, tx_ff);
      w1x = bcr_pkg::wt_inner(t3x_ff, t2x_ff);
      w3x = bcr_pkg::wt_outer(u3x_ff, u2x_ff, ux_ff);
      w0y = bcr_pkg::wt_outer(t3y_ff, t2y_ff, ty_ff);
      w1y = bcr_pkg::wt_inner(t3y_ff, t2y_ff);
      w3y = bcr_pkg::wt_outer(u3y_ff, u2y_ff, uy_ff);
      push_data.func   = func_ff;
      push_data.plane  = plane_ff;
      push_data.row    = row_ff;
      push_data.col    = col_ff;
      push_data.sample = sample_ff;
      push_data.i0x    = i0x_ff;
      push_data.i0y    = i0y_ff;
      push_data.wx[0]  = w0x;
      push_data.wx[1]  = w1x;
      push_data.wx[3]  = w3x;
      push_data.wx[2]  = 18'd16384 - w0x - w1x - w3x;
      push_data.wy[0]  = w0y;
      push_data.wy[1]  = w1y;
      push_data.wy[3]  = w3y;
      push_data.wy[2]  = 18'd16384 - w0y - w1y - w3y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff   <= func_in;
      plane_ff  <= plane_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      sample_ff <= sample_in;
      posx_ff   <= posx_in;
      posy_ff   <= posy_in;
      i0x_ff    <= i0x_in;
      i0y_ff    <= i0y_in;
      tx_ff     <= tx_in;
      ux_ff     <= ux_in;
      ty_ff     <= ty_in;
      uy_ff     <= uy_in;
      t2x_ff    <= t2x_in;
      u2x_ff    <= u2x_in;
      t2y_ff    <= t2y_in;
      u2y_ff    <= u2y_in;
      t3x_ff    <= t3x_in;
      u3x_ff    <= u3x_in;
      t3y_ff    <= t3y_in;
      u3y_ff    <= u3y_in;
   end

endmodule

`default_nettype wire

>>> rtl/bcr_back.sv
// Back part: store samples, filter four rows of four taps, deliver results.
`default_nettype none

module bcr_back #(
   parameter int CHANNELS = bcr_pkg::CHANNELS_DEF,
   parameter int MAX_SIZE = bcr_pkg::MAX_SIZE_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bcr_pkg::cfg_type  cfg,
   input  wire bcr_pkg::item_type head,
   input  wire logic              empty,
   output logic                   pop,
   bcr_rsp_if.source              rsp
);

   localparam int DEPTH = CHANNELS * MAX_SIZE * MAX_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(MAX_SIZE);
   localparam logic [AW-1:0] PLANE_SPAN = AW'(MAX_SIZE * MAX_SIZE);
   localparam logic [AW-1:0] ROW_SPAN   = AW'(MAX_SIZE);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_RUN  = 3'b010,
      B_FIN  = 3'b100
   } bstate_type;

   bstate_type state_ff, state_in;
   bcr_pkg::item_type cur_ff, cur_in;
   logic [2:0] issue_ff, issue_in;
   logic v1_ff, v2_ff, v3_ff, v4_ff, last4_ff;
   logic [1:0] row1_ff, row2_ff, row3_ff;
   logic signed [33:0] prod_ff [4];
   logic signed [21:0] hr_ff;
   logic signed [39:0] vp_ff;
   logic signed [41:0] acc_ff, acc_in;
   logic out_vld_ff, out_vld_in;
   logic [15:0] value_ff, value_in;
   logic clip_ff, clip_in;

   logic we, re;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr [4];
   logic [15:0]   rdata [4];
   logic signed [16:0] lim_x, lim_y, cy;
   logic signed [16:0] cx [4];
   logic signed [35:0] hsum;
   logic signed [41:0] accr;
   logic head_ok;

   function automatic logic signed [16:0] clamp_tap(input logic signed [16:0] c,
                                                    input logic signed [16:0] lim);
      if (c < 17'sd0) begin
         return 17'sd0;
      end else if (c > lim) begin
         return lim;
      end
      return c;
   endfunction

   function automatic logic signed [16:0] size_lim(input logic [7:0] r);
      if (r == 8'd0) begin
         return 17'sd0;
      end else if (32'(r) > MAX_SIZE) begin
         return 17'(MAX_SIZE - 1);
      end
      return 17'(r) - 17'sd1;
   endfunction

   generate
      for (genvar k = 0; k < 4; k++) begin : g_bank
         bcr_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
            .clock (clock),
            .we    (we),
            .waddr (waddr),
            .wdata (head.sample),
            .re    (re),
            .raddr (raddr[k]),
            .rdata (rdata[k])
         );
      end
   endgenerate

   always_comb begin
      lim_x = size_lim(cfg.src_width);
      lim_y = size_lim(cfg.src_height);
      cy    = clamp_tap($signed(cur_ff.i0y) + 17'($signed({1'b0, issue_ff[1:0]})) - 17'sd1,
                        lim_y);
      for (int k = 0; k < 4; k++) begin
         cx[k]    = clamp_tap($signed(cur_ff.i0x) + 17'(k) - 17'sd1, lim_x);
         raddr[k] = AW'(cur_ff.plane) * PLANE_SPAN + AW'(cy[SW-1:0]) * ROW_SPAN
                    + AW'(cx[k][SW-1:0]);
      end
      waddr   = AW'(head.plane) * PLANE_SPAN + AW'(head.row) * ROW_SPAN + AW'(head.col);
      head_ok = 32'(head.plane) < CHANNELS;
      hsum = 36'(prod_ff[0]) + 36'(prod_ff[1]) + 36'(prod_ff[2]) + 36'(prod_ff[3]);
      accr = (acc_ff + 42'sd8192) >>> 14;
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      issue_in   = issue_ff;
      acc_in     = acc_ff;
      out_vld_in = out_vld_ff && !rsp.ready;
      value_in   = value_ff;
      clip_in    = clip_ff;
      pop        = 1'b0;
      we         = 1'b0;
      re         = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cur_in = head;
               if (head.func == bcr_pkg::FUNC_LOAD) begin
                  we = head_ok && (32'(head.row) < MAX_SIZE) && (32'(head.col) < MAX_SIZE);
               end else begin
                  acc_in   = 42'sd0;
                  issue_in = 3'd0;
                  state_in = head_ok ? B_RUN : B_FIN;
               end
            end
         end
         B_RUN: begin
            if (issue_ff != 3'd4) begin
               re       = 1'b1;
               issue_in = issue_ff + 3'd1;
            end
            if (v4_ff) begin
               acc_in = acc_ff + 42'(vp_ff);
               if (last4_ff) begin
                  state_in = B_FIN;
               end
            end
         end
         B_FIN: begin
            if (!out_vld_ff || rsp.ready) begin
               out_vld_in = 1'b1;
               if (accr > 42'sd32767) begin
                  value_in = 16'h7fff;
                  clip_in  = 1'b1;
               end else if (accr < -42'sd32768) begin
                  value_in = 16'h8000;
                  clip_in  = 1'b1;
               end else begin
                  value_in = accr[15:0];
                  clip_in  = 1'b0;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.value   = value_ff;
   assign rsp.clipped = clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         v1_ff      <= re;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         out_vld_ff <= out_vld_in;
      end
      cur_ff   <= cur_in;
      issue_ff <= issue_in;
      acc_ff   <= acc_in;
      value_ff <= value_in;
      clip_ff  <= clip_in;
      row1_ff  <= issue_ff[1:0];
      row2_ff  <= row1_ff;
      row3_ff  <= row2_ff;
      last4_ff <= (row3_ff == 2'd3);
      for (int k = 0; k < 4; k++) begin
         prod_ff[k] <= $signed(rdata[k]) * $signed(cur_ff.wx[k]);
      end
      hr_ff <= 22'((hsum + 36'sd8192) >>> 14);
      vp_ff <= $signed(cur_ff.wy[row3_ff]) * hr_ff;
   end

endmodule

`default_nettype wire

>>> rtl/bicubic_image_resampler.sv
// Top level of the bicubic image resampler.
// Separable bicubic resampler (cubic convolution, a = -0.75, pixel-center alignment,
// edge-clamped taps). A word with func 0 stores one Q3.12 sample of a plane; a word
// with func 1 returns one Q3.12 destination sample and a saturation flag. The front
// part computes positions and weights, taking a word only once the last is queued;
// the back part stores samples and filters a request by reading one source row per
// cycle from four copies of the sample store. A two-entry queue lets the parts stall
// independently. Configuration must be written while idle; the block has no check.
`default_nettype none

module bicubic_image_resampler #(
   parameter int CHANNELS = bcr_pkg::CHANNELS_DEF,
   parameter int MAX_SIZE = bcr_pkg::MAX_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bcr_req_if.sink          req,
   bcr_rsp_if.source        rsp,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   bcr_pkg::cfg_type  cfg_ff;
   bcr_pkg::item_type push_data, head;
   logic push, full, pop, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_height      <= 8'd128;
         cfg_ff.src_width       <= 8'd128;
         cfg_ff.vertical_step   <= 24'd65536;
         cfg_ff.horizontal_step <= 24'd65536;
      end else if (csr_wr_en) begin
         unique case (bcr_pkg::csr_idx_type'(csr_index))
            bcr_pkg::CSR_SRC_HEIGHT:      cfg_ff.src_height      <= csr_data[7:0];
            bcr_pkg::CSR_SRC_WIDTH:       cfg_ff.src_width       <= csr_data[7:0];
            bcr_pkg::CSR_VERTICAL_STEP:   cfg_ff.vertical_step   <= csr_data;
            bcr_pkg::CSR_HORIZONTAL_STEP: cfg_ff.horizontal_step <= csr_data;
            default: ;
         endcase
      end
   end

   bcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   bcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   bcr_back #(.CHANNELS(CHANNELS), .MAX_SIZE(MAX_SIZE)) u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Testbench for the bicubic image resampler: directed and random loads and requests.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [23:0] csr_data;

   bcr_req_if req ();
   bcr_rsp_if rsp ();

   bicubic_image_resampler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   typedef struct {
      logic signed [15:0] value;
      logic               clipped;
   } pixel_type;

   logic signed [15:0] src_plane [0:3][0:127][0:127];
   bit                 written [0:3][0:127][0:127];
   int unsigned        height_q, width_q, vstep_q, hstep_q;
   pixel_type          pixel_q [$];
   int                 error_count;
   int                 send_idle_pct;
   int                 recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report(input string msg);
      error_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   function automatic longint floor_div(input longint v, input int n);
      return v >>> n;
   endfunction

   function automatic longint round_div(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic int unsigned fit_size(input int unsigned r);
      if (r < 1) return 1;
      if (r > 128) return 128;
      return r;
   endfunction

   function automatic void kernel_taps(input int unsigned d, input int unsigned step,
                                       input int unsigned size, output int idx[4],
                                       output longint w[4]);
      longint pos, i0, t, u, s, c;
      s = 16384;
      pos = longint'(2 * d + 1) * longint'(step) - 65536;
      i0 = floor_div(pos, 17);
      t = (pos - i0 * 131072) >>> 3;
      u = s - t;
      w[0] = round_div(-3 * (t * t * t - 2 * t * t * s + t * s * s), 30);
      w[1] = round_div(5 * t * t * t - 9 * t * t * s + 4 * s * s * s, 30);
      w[3] = round_div(-3 * (u * u * u - 2 * u * u * s + u * s * s), 30);
      w[2] = 16384 - w[0] - w[1] - w[3];
      for (int k = 0; k < 4; k++) begin
         c = i0 - 1 + k;
         if (c < 0) c = 0;
         if (c > size - 1) c = size - 1;
         idx[k] = int'(c);
      end
   endfunction

   function automatic pixel_type interpolate(input int plane, input int row, input int col);
      pixel_type p;
      int hx[4], vy[4];
      longint wx[4], wy[4];
      longint acc, h, val;
      kernel_taps(col, hstep_q, fit_size(width_q), hx, wx);
      kernel_taps(row, vstep_q, fit_size(height_q), vy, wy);
      acc = 0;
      for (int r = 0; r < 4; r++) begin
         h = 0;
         for (int k = 0; k < 4; k++) h += wx[k] * longint'(src_plane[plane][vy[r]][hx[k]]);
         acc += wy[r] * round_div(h, 14);
      end
      val = round_div(acc, 14);
      p.clipped = 1'b0;
      if (val > 32767) begin
         val = 32767;
         p.clipped = 1'b1;
      end
      if (val < -32768) begin
         val = -32768;
         p.clipped = 1'b1;
      end
      p.value = 16'(val);
      return p;
   endfunction

   task automatic write_csr(input bcr_pkg::csr_idx_type idx, input int unsigned data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= 24'(data);
      case (idx)
         bcr_pkg::CSR_SRC_HEIGHT:      height_q = data & 8'hFF;
         bcr_pkg::CSR_SRC_WIDTH:       width_q = data & 8'hFF;
         bcr_pkg::CSR_VERTICAL_STEP:   vstep_q = data & 24'hFFFFFF;
         bcr_pkg::CSR_HORIZONTAL_STEP: hstep_q = data & 24'hFFFFFF;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_word(input logic func, input logic [1:0] plane, input logic [6:0] row,
                            input logic [6:0] col, input logic [15:0] sample);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid  <= 1'b1;
      req.func   <= func;
      req.plane  <= plane;
      req.row    <= row;
      req.col    <= col;
      req.sample <= sample;
      do @(posedge clock); while (!req.ready);
      if (func == bcr_pkg::FUNC_LOAD) begin
         src_plane[plane][row][col] = sample;
         written[plane][row][col] = 1'b1;
      end else begin
         pixel_q.push_back(interpolate(plane, row, col));
      end
   endtask

   // only request pixels whose taps all hit written samples
   function automatic bit taps_written(input int plane, input int row, input int col);
      int hx[4], vy[4];
      longint wx[4], wy[4];
      kernel_taps(col, hstep_q, fit_size(width_q), hx, wx);
      kernel_taps(row, vstep_q, fit_size(height_q), vy, wy);
      for (int r = 0; r < 4; r++)
         for (int k = 0; k < 4; k++)
            if (!written[plane][vy[r]][hx[k]]) return 0;
      return 1;
   endfunction

   task automatic drain();
      req.valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic fill_window(input int plane, input int rows, input int cols, input int mode);
      logic [15:0] s;
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < cols; c++) begin
            case (mode)
               0: s = 16'h7FFF;
               1: s = 16'h8000;
               default: s = 16'($urandom);
            endcase
            send_word(bcr_pkg::FUNC_LOAD, 2'(plane), 7'(r), 7'(c), s);
         end
   endtask

   task automatic test_directed();
      write_csr(bcr_pkg::CSR_SRC_HEIGHT, 4);
      write_csr(bcr_pkg::CSR_SRC_WIDTH, 4);
      write_csr(bcr_pkg::CSR_VERTICAL_STEP, 32768);
      write_csr(bcr_pkg::CSR_HORIZONTAL_STEP, 32768);
      fill_window(3, 4, 4, 2);
      send_word(bcr_pkg::FUNC_REQ, 2'd3, 7'd0, 7'd0, 16'hFFFF);
      send_word(bcr_pkg::FUNC_REQ, 2'd3, 7'd7, 7'd7, 16'h0000);
      send_word(bcr_pkg::FUNC_REQ, 2'd3, 7'd127, 7'd127, 16'h0000);
      send_word(bcr_pkg::FUNC_REQ, 2'd3, 7'd3, 7'd5, 16'h0000);
      drain();
      // checkerboard of extremes drives overshoot into saturation
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            send_word(bcr_pkg::FUNC_LOAD, 2'd2, 7'(r), 7'(c),
                      ((r + c) % 2) ? 16'h8000 : 16'h7FFF);
      for (int k = 0; k < 4; k++)
         send_word(bcr_pkg::FUNC_REQ, 2'd2, 7'(k), 7'(3 - k), 16'h0000);
      drain();
      write_csr(bcr_pkg::CSR_VERTICAL_STEP, 0);
      write_csr(bcr_pkg::CSR_HORIZONTAL_STEP, 24'hFFFFFF);
      send_word(bcr_pkg::FUNC_REQ, 2'd2, 7'd127, 7'd1, 16'h0000);
      drain();
      write_csr(bcr_pkg::CSR_SRC_HEIGHT, 0);
      write_csr(bcr_pkg::CSR_SRC_WIDTH, 255);
      write_csr(bcr_pkg::CSR_VERTICAL_STEP, 1);
      write_csr(bcr_pkg::CSR_HORIZONTAL_STEP, 1);
      fill_window(1, 1, 2, 1);
      send_word(bcr_pkg::FUNC_REQ, 2'd1, 7'd127, 7'd0, 16'h0000);
      drain();
   endtask

   task automatic test_random(input int items, input int size, input int step_max);
      int p, tries;
      int unsigned rr, cc;
      write_csr(bcr_pkg::CSR_SRC_HEIGHT, $urandom_range(size, 1));
      write_csr(bcr_pkg::CSR_SRC_WIDTH, $urandom_range(size, 1));
      write_csr(bcr_pkg::CSR_VERTICAL_STEP, $urandom_range(step_max, 1));
      write_csr(bcr_pkg::CSR_HORIZONTAL_STEP, $urandom_range(step_max, 1));
      p = $urandom_range(3);
      fill_window(p, fit_size(height_q), fit_size(width_q), 2);
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(3) == 0) begin
            send_word(bcr_pkg::FUNC_LOAD, 2'(p), 7'($urandom_range(fit_size(height_q) - 1)),
                      7'($urandom_range(fit_size(width_q) - 1)), 16'($urandom));
         end else begin
            tries = 0;
            do begin
               rr = $urandom_range(127);
               cc = $urandom_range(127);
               tries++;
            end while (!taps_written(p, rr, cc) && tries < 50);
            if (taps_written(p, rr, cc))
               send_word(bcr_pkg::FUNC_REQ, 2'(p), 7'(rr), 7'(cc), 16'($urandom));
         end
      end
      drain();
   endtask

   task automatic test_phases();
      int idle_pct[4] = '{0, 57, 0, 26};
      int stall_pct[4] = '{0, 0, 57, 26};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_pct[ph];
         recv_stall_pct = stall_pct[ph];
         test_random(25, 6, 200000);
         test_random(25, 8, 24'hFFFFFF);
         test_random(25, 10, 70000);
      end
   endtask

   initial begin : checker_proc
      pixel_type exp_pix;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (pixel_q.size() == 0) begin
               report("result with nothing expected");
            end else begin
               exp_pix = pixel_q.pop_front();
               if (rsp.value !== exp_pix.value)
                  report($sformatf("value %h, expected %h", rsp.value, exp_pix.value));
               if (rsp.clipped !== exp_pix.clipped)
                  report($sformatf("clipped %b, expected %b", rsp.clipped, exp_pix.clipped));
            end
         end
         rsp.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = bcr_pkg::CSR_SRC_HEIGHT;
      csr_data = '0;
      req.valid = 1'b0;
      req.func = bcr_pkg::FUNC_LOAD;
      req.plane = '0;
      req.row = '0;
      req.col = '0;
      req.sample = '0;
      rsp.ready = 1'b1;
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      height_q = 128;
      width_q = 128;
      vstep_q = 65536;
      hstep_q = 65536;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_directed();
      test_phases();
      drain();
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
